@@ rtl/poi_pkg.sv @@
// Shared constants, types and tables for the planar odometry integrator.
package poi_pkg;

	localparam int TRIG_FRAC_BITS = 14;
	localparam int CORDIC_STEPS = 16;
	localparam int CQ = 30;
	localparam int CW = 34;
	localparam int IDX_W = $clog2(CORDIC_STEPS + 1);
	localparam logic [CW-1:0] INV_GAIN = CW'(652032874);
	localparam logic [27:0] RAD_TO_TURN = 28'd42722830;
	localparam int MUL_W = 38;

	localparam logic [0:0] REG_MAX_INTERVAL = 1'b0;

	typedef struct packed {
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
	} trig_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// round to nearest, ties away from zero, by 2^s
	function automatic logic signed [79:0] rnd(input logic signed [79:0] v, input int s);
		logic [79:0] mag;
		logic [79:0] half;
		half = 80'd1 << (s - 1);
		mag = v[79] ? 80'(-v) : 80'(v);
		mag = (mag + half) >> s;
		return v[79] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

@@ rtl/poi_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module poi_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] angle,
	output logic done,
	output poi_pkg::trig_t res
);
	logic signed [poi_pkg::CW-1:0] x_q, y_q, a_q;
	logic [poi_pkg::IDX_W-1:0] i_q;
	logic busy_q, flip_q;
	logic signed [poi_pkg::CW-1:0] a0, xs, ys;
	logic [4:0] i5;

	assign i5 = 5'(i_q);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_comb begin
		a0 = poi_pkg::CW'($signed(angle));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == poi_pkg::IDX_W'(poi_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= poi_pkg::INV_GAIN;
			y_q <= '0;
			if (a0 > poi_pkg::CW'(34'sh40000000)) begin
				a_q <= a0 - poi_pkg::CW'(34'sh80000000);
				flip_q <= 1'b1;
			end else if (a0 < -poi_pkg::CW'(34'sh40000000)) begin
				a_q <= a0 + poi_pkg::CW'(34'sh80000000);
				flip_q <= 1'b1;
			end else begin
				a_q <= a0;
				flip_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!a_q[poi_pkg::CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				a_q <= a_q - $signed({2'b0, poi_pkg::atan_turn(i5)});
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				a_q <= a_q + $signed({2'b0, poi_pkg::atan_turn(i5)});
			end
		end
	end

	assign res.c = flip_q ? -x_q : x_q;
	assign res.s = flip_q ? -y_q : y_q;
endmodule

@@ rtl/poi_serial_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle.
module poi_serial_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [poi_pkg::MUL_W-1:0] a,
	input  logic [poi_pkg::MUL_W-1:0] b,
	output logic done,
	output logic signed [79:0] prod
);
	logic [poi_pkg::MUL_W-1:0] b_q;
	logic signed [79:0] a_q;
	logic [5:0] n_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= '0;
			end else if (busy_q) begin
				n_q <= n_q + 1'b1;
				if (n_q == 6'(poi_pkg::MUL_W - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= 80'(a);
			b_q <= b;
			prod <= '0;
		end else if (busy_q) begin
			if (b_q[0]) prod <= prod + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end
endmodule

@@ rtl/planar_odometry_integrator.sv @@
// Top level of the planar odometry integrator.
// Usage: ticks enter on the s_axis channel (vel_x, vel_y, yaw_rate, interval).
// A tick with zero interval, or interval above max_interval, is taken,
// dropped, and produces no transfer. Otherwise the pose and yaw
// quaternion leave on the m_axis channel. max_interval is written over the
// APB port at address 0.
// Each tick runs through a 16-step CORDIC for the old heading, eight serial
// multiplies (four for the two velocity dot products, dx*dt, dy*dt, yaw*dt and
// the heading step; one multiplier bit per cycle), then a second CORDIC for
// the half heading. m_axis_tvalid rises once the second CORDIC is done; the
// next tick is taken only after the result has been taken, and the tick rate
// is set mostly by the shared shift-add multiplier. One tick is in flight at a
// time.
// Reset clears position and heading and sets max_interval to one second.
// The result is held in an output register; while the receiver stalls the
// block holds it and accepts no new tick until it has been taken.
module planar_odometry_integrator (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [71:0] s_axis_tdata, // vel_x, vel_y, yaw_rate, interval
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [111:0] m_axis_tdata, // pos_x, pos_y, heading_angle, quat_z, quat_w
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001, ST_COR1 = 5'b00010, ST_MUL = 5'b00100,
		ST_COR2 = 5'b01000, ST_WAIT = 5'b10000
	} state_t;

	state_t st_q;
	logic [20:0] max_q, dt_q;
	logic signed [15:0] vx_q, vy_q, wz_q;
	logic signed [31:0] wx_q, wy_q;
	logic [31:0] hd_q;
	logic signed [poi_pkg::MUL_W-1:0] c_q, s_q, acc_q;
	logic signed [poi_pkg::MUL_W-1:0] ex_q;
	logic [2:0] ph_q;
	logic mul_go_q, cor_go_q;
	logic cor_start, cor_done, mul_start, mul_done;
	logic [31:0] cor_angle;
	poi_pkg::trig_t cor_res;
	logic signed [poi_pkg::MUL_W-1:0] mul_a;
	logic [poi_pkg::MUL_W-1:0] mul_b;
	logic signed [79:0] prod;
	logic signed [79:0] dsum;
	logic signed [79:0] qz, qw;
	logic [63:0] step;
	logic [31:0] half;
	logic ok;
	logic [15:0] qz_q, qw_q;
	logic [20:0] in_dt;

	assign pready = 1'b1;
	assign prdata = (paddr == {poi_pkg::REG_MAX_INTERVAL, 1'b0}) ? {11'b0, max_q} : 32'b0;
	assign in_dt = s_axis_tdata[68:48];
	assign ok = (in_dt != 21'd0) && (in_dt <= max_q);
	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_WAIT);
	assign m_axis_tdata = {qw_q, qz_q, hd_q[31:16], wy_q, wx_q};
	assign half = {hd_q[31], hd_q[31:1]};
	assign cor_angle = (st_q == ST_IDLE) ? hd_q : half;

	poi_cordic u_cor (.clk, .arst_n, .start(cor_start), .angle(cor_angle),
		.done(cor_done), .res(cor_res));
	poi_serial_mul u_mul (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(prod));

	// multiply schedule: ph 0..3 products of the velocity dot, 4 dx*dt, 5 dy*dt,
	// 6 yaw*dt, 7 |p|*rad_to_turn
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ph_q)
			3'd0: begin mul_a = poi_pkg::MUL_W'(vx_q); mul_b = poi_pkg::MUL_W'(c_q); end
			3'd1: begin mul_a = poi_pkg::MUL_W'(vy_q); mul_b = poi_pkg::MUL_W'(s_q); end
			3'd2: begin mul_a = poi_pkg::MUL_W'(vx_q); mul_b = poi_pkg::MUL_W'(s_q); end
			3'd3: begin mul_a = poi_pkg::MUL_W'(vy_q); mul_b = poi_pkg::MUL_W'(c_q); end
			3'd4: begin mul_a = ex_q; mul_b = poi_pkg::MUL_W'(dt_q); end
			3'd5: begin mul_a = acc_q; mul_b = poi_pkg::MUL_W'(dt_q); end
			3'd6: begin mul_a = poi_pkg::MUL_W'(wz_q); mul_b = poi_pkg::MUL_W'(dt_q); end
			3'd7: begin
				mul_a = acc_q[poi_pkg::MUL_W-1] ? -acc_q : acc_q;
				mul_b = poi_pkg::MUL_W'(poi_pkg::RAD_TO_TURN);
			end
			default: ;
		endcase
	end

	// c_q/s_q hold unsigned bit patterns; b input is taken as signed below
	logic signed [79:0] prod_fix;
	assign prod_fix = (ph_q <= 3'd5 && mul_b[poi_pkg::MUL_W-1])
		? prod - (80'(mul_a) <<< poi_pkg::MUL_W) : prod;
	assign dsum = poi_pkg::rnd(prod_fix, 16 + poi_pkg::TRIG_FRAC_BITS);
	assign qz = poi_pkg::rnd(80'(cor_res.s), poi_pkg::CQ - 14);
	assign qw = poi_pkg::rnd(80'(cor_res.c), poi_pkg::CQ - 14);
	assign step = 64'((prod + 80'sd134217728) >>> 28);

	function automatic logic signed [31:0] sat(input logic signed [79:0] v);
		if (v > 80'sd2147483647) return 32'sh7fffffff;
		if (v < -80'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// each unit starts in the cycle after the previous step lands, so the
	// operands and the heading it reads are already updated
	assign cor_start = (st_q == ST_IDLE && s_axis_tvalid && ok) || cor_go_q;
	assign mul_start = mul_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			max_q <= 21'd1048576;
			wx_q <= '0;
			wy_q <= '0;
			hd_q <= '0;
			ph_q <= '0;
			acc_q <= '0;
			qz_q <= '0;
			qw_q <= '0;
			mul_go_q <= 1'b0;
			cor_go_q <= 1'b0;
		end else begin
			mul_go_q <= (st_q == ST_COR1 && cor_done)
				|| (st_q == ST_MUL && mul_done && ph_q != 3'd7);
			cor_go_q <= (st_q == ST_MUL && mul_done && ph_q == 3'd7);
			if (psel && penable && pwrite && paddr == {poi_pkg::REG_MAX_INTERVAL, 1'b0})
				max_q <= pwdata[20:0];
			unique case (st_q)
				ST_IDLE: if (s_axis_tvalid && ok) begin
					st_q <= ST_COR1;
					ph_q <= 3'd0;
				end
				ST_COR1: if (cor_done) st_q <= ST_MUL;
				ST_MUL: if (mul_done) begin
					unique case (ph_q)
						3'd0, 3'd2: acc_q <= poi_pkg::MUL_W'(prod_fix);
						3'd1: acc_q <= acc_q - poi_pkg::MUL_W'(prod_fix);
						3'd3: acc_q <= acc_q + poi_pkg::MUL_W'(prod_fix);
						3'd4: wx_q <= sat(80'(wx_q) + dsum);
						3'd5: wy_q <= sat(80'(wy_q) + dsum);
						3'd6: acc_q <= poi_pkg::MUL_W'(prod);
						default: hd_q <= acc_q[poi_pkg::MUL_W-1] ? hd_q - step[31:0]
							: hd_q + step[31:0];
					endcase
					ph_q <= ph_q + 1'b1;
					if (ph_q == 3'd7) st_q <= ST_COR2;
				end
				ST_COR2: if (cor_done) begin
					qz_q <= qz[15:0];
					qw_q <= qw[15:0];
					st_q <= ST_WAIT;
				end
				ST_WAIT: if (m_axis_tready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// dot products need to keep the first pair: save vx*c-vy*s before ph2
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_axis_tvalid) begin
			vx_q <= s_axis_tdata[15:0];
			vy_q <= s_axis_tdata[31:16];
			wz_q <= s_axis_tdata[47:32];
			dt_q <= in_dt;
		end
		if (st_q == ST_COR1 && cor_done) begin
			c_q <= poi_pkg::MUL_W'(poi_pkg::rnd(80'(cor_res.c),
				poi_pkg::CQ - poi_pkg::TRIG_FRAC_BITS));
			s_q <= poi_pkg::MUL_W'(poi_pkg::rnd(80'(cor_res.s),
				poi_pkg::CQ - poi_pkg::TRIG_FRAC_BITS));
		end
		if (st_q == ST_MUL && mul_done && ph_q == 3'd1) ex_q <= acc_q - poi_pkg::MUL_W'(prod_fix);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while holding result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state code");
endmodule
